>>> rtl/ipv4_route_table_lookup_defines.svh
// Assertion macros used by the route table top level.
`ifndef IPV4_ROUTE_TABLE_LOOKUP_DEFINES_SVH
`define IPV4_ROUTE_TABLE_LOOKUP_DEFINES_SVH

// Concurrent invariant that must hold at every rising clock edge out of reset.
`define IPRT_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Property that must hold in the cycle after the trigger.
`define IPRT_ASSERT_NEXT(lbl, trig, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) else $error(msg);

`endif

>>> rtl/iprt_pkg.sv
// Package with the types, codes and helper functions of the route table.
`timescale 1ns / 1ps
package iprt_pkg;

	localparam int HOST_ENTRIES = 64;
	localparam int NET_ENTRIES  = 64;
	localparam logic [15:0] DEFAULT_MTU_RESET = 16'd1500;
	localparam logic [5:0]  PLEN_MAX = 6'd32;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_DEL    = 2'd1,
		FN_LOOKUP = 2'd2,
		FN_FLUSH  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_EXISTS = 2'd1,
		STS_MISS   = 2'd2,
		STS_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_CMP   = 2'd1,
		S_APPLY = 2'd2
	} state_t;

	typedef enum logic [2:0] {
		OP_HOLD  = 3'd0,
		OP_NEW   = 3'd1,
		OP_PREV  = 3'd2,
		OP_NEXT  = 3'd3,
		OP_CLEAR = 3'd4
	} cell_op_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [5:0]  plen;
		logic [7:0]  port;
		logic [1:0]  kind;
		logic [31:0] gw;
		logic [31:0] src;
		logic [15:0] mtu;
		logic [15:0] metric;
	} entry_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [5:0]  plen;
		logic [7:0]  port;
	} query_t;

	// Compare results of one cell against the current request.
	typedef struct packed {
		logic addr_eq;
		logic host_dup;
		logic net_dup;
		logic keep;
		logic net_del;
		logic cover_hit;
	} cell_flags_t;

	function automatic logic [31:0] plen_mask(input logic [5:0] p);
		logic [31:0] m;
		if (p == 6'd0) begin
			m = 32'd0;
		end else if (p >= PLEN_MAX) begin
			m = 32'hFFFF_FFFF;
		end else begin
			m = ~(32'hFFFF_FFFF >> p);
		end
		return m;
	endfunction

endpackage

>>> rtl/ipv4_route_table_lookup.sv
// Top level of the IPv4 route table: host and net cell chains, control and stream ports.
`timescale 1ns / 1ps
// Each request passes through the transfer into a request register, a compare step in which
// every cell compares its entry and registers the outcome, and an apply step that resolves the
// first match along each chain, shifts the cells and loads the result register.
// A new request is taken only once the previous one has been applied; a held result stalls the
// apply step. After arst_n both chains are empty and default_mtu is 1500.
module ipv4_route_table_lookup (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// dest_addr, prefix_len, port_id, gateway_addr, source_addr, route_mtu, route_metric
	input  logic [143:0]  s_axis_tdata,
	// func, route_kind
	input  logic [3:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// hit_prefix_len, hit_port, hit_gateway, hit_source, hit_mtu, hit_metric
	output logic [111:0]  m_axis_tdata,
	// status, hit, hit_kind
	output logic [4:0]    m_axis_tuser,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   cfg_data
);
	import iprt_pkg::*;
	`include "ipv4_route_table_lookup_defines.svh"

	localparam int HN = HOST_ENTRIES;
	localparam int NN = NET_ENTRIES;

	state_t      state_q;
	state_t      state_d;
	logic        in_acc;
	logic        cmp_en;
	logic        apply_go;
	logic [15:0] mtu_q;

	// Request register, loaded on each input transfer.
	func_t       func_q;
	logic [1:0]  kind_q;
	entry_t      req_q;
	logic [5:0]  plen_in;
	query_t      query;
	entry_t      new_ent;
	logic        is_host;

	entry_t      h_ent [HN];
	logic [HN-1:0] h_vld;
	cell_flags_t h_flag [HN];
	cell_op_t    h_op [HN];
	entry_t      n_ent [NN];
	logic [NN-1:0] n_vld;
	cell_flags_t n_flag [NN];
	cell_op_t    n_op [NN];

	logic [HN:0] h_seen;
	logic [NN:0] nd_seen;
	logic [NN:0] nc_seen;
	logic        h_dup_any;
	logic        n_dup_any;
	entry_t      h_sel;
	entry_t      n_sel;

	logic        h_ins;
	logic        n_ins;
	logic        h_del;
	logic        n_del;
	logic        flush;
	status_t     res_status;
	logic        res_hit;
	entry_t      res_ent;

	logic        out_valid_q;
	status_t     out_status_q;
	logic        out_hit_q;
	entry_t      out_ent_q;

	logic [HN-1:0] h_vld_inc;
	logic [NN-1:0] n_vld_inc;

	// Configuration register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mtu_q <= DEFAULT_MTU_RESET;
		end else if (cfg_valid) begin
			mtu_q <= cfg_data;
		end
	end

	// Control sequencer.
	always_comb begin
		case (state_q)
			S_IDLE:  state_d = in_acc ? S_CMP : S_IDLE;
			S_CMP:   state_d = S_APPLY;
			S_APPLY: state_d = apply_go ? S_IDLE : S_APPLY;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = state_q == S_IDLE;
		cmp_en        = state_q == S_CMP;
		apply_go      = (state_q == S_APPLY) && (!out_valid_q || m_axis_tready);
	end

	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Prefix lengths above 32 are treated and stored as 32.
	assign plen_in = (s_axis_tdata[37:32] > PLEN_MAX) ? PLEN_MAX : s_axis_tdata[37:32];

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q      <= func_t'(s_axis_tuser[1:0]);
			kind_q      <= s_axis_tuser[3:2];
			req_q.addr  <= s_axis_tdata[31:0];
			req_q.plen  <= plen_in;
			req_q.port  <= s_axis_tdata[45:38];
			req_q.kind  <= s_axis_tuser[3:2];
			req_q.gw    <= s_axis_tdata[77:46];
			req_q.src   <= s_axis_tdata[109:78];
			req_q.mtu   <= s_axis_tdata[125:110];
			req_q.metric <= s_axis_tdata[141:126];
		end
	end

	always_comb begin
		query.addr = req_q.addr;
		query.plen = req_q.plen;
		query.port = req_q.port;
		new_ent    = req_q;
		if (req_q.mtu == 16'd0) begin
			new_ent.mtu = mtu_q;
		end
		is_host = !kind_q[1];
	end

	// Host chain: newest entry in cell 0.
	for (genvar i = 0; i < HN; i++) begin : g_host
		iprt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (h_op[i]),
			.new_ent    (new_ent),
			.prev_ent   ((i == 0) ? entry_t'('0) : h_ent[(i == 0) ? 0 : i - 1]),
			.prev_valid ((i == 0) ? 1'b0 : h_vld[(i == 0) ? 0 : i - 1]),
			.next_ent   ((i == HN - 1) ? entry_t'('0) : h_ent[(i == HN - 1) ? i : i + 1]),
			.next_valid ((i == HN - 1) ? 1'b0 : h_vld[(i == HN - 1) ? i : i + 1]),
			.query      (query),
			.cmp_en     (cmp_en),
			.ent        (h_ent[i]),
			.valid      (h_vld[i]),
			.flags      (h_flag[i])
		);
	end

	// Net chain: entries in order of falling prefix length.
	for (genvar i = 0; i < NN; i++) begin : g_net
		iprt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (n_op[i]),
			.new_ent    (new_ent),
			.prev_ent   ((i == 0) ? entry_t'('0) : n_ent[(i == 0) ? 0 : i - 1]),
			.prev_valid ((i == 0) ? 1'b0 : n_vld[(i == 0) ? 0 : i - 1]),
			.next_ent   ((i == NN - 1) ? entry_t'('0) : n_ent[(i == NN - 1) ? i : i + 1]),
			.next_valid ((i == NN - 1) ? 1'b0 : n_vld[(i == NN - 1) ? i : i + 1]),
			.query      (query),
			.cmp_en     (cmp_en),
			.ent        (n_ent[i]),
			.valid      (n_vld[i]),
			.flags      (n_flag[i])
		);
	end

	// The seen chains mark every cell at or behind the first match, which both picks the
	// matching entry for a lookup and selects the cells that close the gap on a delete.
	always_comb begin
		h_seen[0]  = 1'b0;
		h_dup_any  = 1'b0;
		h_sel      = '0;
		for (int i = 0; i < HN; i++) begin
			h_seen[i+1] = h_seen[i] | h_flag[i].addr_eq;
			h_dup_any   = h_dup_any | h_flag[i].host_dup;
			h_sel       = h_sel | ((h_flag[i].addr_eq && !h_seen[i]) ? h_ent[i] : entry_t'('0));
		end
	end

	always_comb begin
		nd_seen[0] = 1'b0;
		nc_seen[0] = 1'b0;
		n_dup_any  = 1'b0;
		n_sel      = '0;
		for (int i = 0; i < NN; i++) begin
			nd_seen[i+1] = nd_seen[i] | n_flag[i].net_del;
			nc_seen[i+1] = nc_seen[i] | n_flag[i].cover_hit;
			n_dup_any    = n_dup_any | n_flag[i].net_dup;
			n_sel        = n_sel | ((n_flag[i].cover_hit && !nc_seen[i]) ? n_ent[i]
				: entry_t'('0));
		end
	end

	// Result of the current request and the chain updates it causes.
	always_comb begin
		res_status = STS_OK;
		res_hit    = 1'b0;
		res_ent    = '0;
		h_ins      = 1'b0;
		n_ins      = 1'b0;
		h_del      = 1'b0;
		n_del      = 1'b0;
		flush      = 1'b0;
		case (func_q)
			FN_ADD: begin
				if (is_host) begin
					if (h_dup_any) begin
						res_status = STS_EXISTS;
					end else if (h_vld[HN-1]) begin
						res_status = STS_FULL;
					end else begin
						h_ins = 1'b1;
					end
				end else begin
					if (n_dup_any) begin
						res_status = STS_EXISTS;
					end else if (n_vld[NN-1]) begin
						res_status = STS_FULL;
					end else begin
						n_ins = 1'b1;
					end
				end
			end
			FN_DEL: begin
				if (is_host) begin
					h_del      = 1'b1;
					res_status = h_seen[HN] ? STS_OK : STS_MISS;
				end else begin
					n_del      = 1'b1;
					res_status = nd_seen[NN] ? STS_OK : STS_MISS;
				end
			end
			FN_LOOKUP: begin
				if (h_seen[HN]) begin
					res_hit = 1'b1;
					res_ent = h_sel;
				end else if (nc_seen[NN]) begin
					res_hit = 1'b1;
					res_ent = n_sel;
				end else begin
					res_status = STS_MISS;
				end
			end
			FN_FLUSH: flush = 1'b1;
			default:  res_status = STS_OK;
		endcase
	end

	always_comb begin
		for (int i = 0; i < HN; i++) begin
			h_op[i] = OP_HOLD;
			if (apply_go) begin
				if (flush) begin
					h_op[i] = OP_CLEAR;
				end else if (h_ins) begin
					h_op[i] = (i == 0) ? OP_NEW : OP_PREV;
				end else if (h_del && h_seen[i+1]) begin
					h_op[i] = OP_NEXT;
				end
			end
		end
	end

	// Cells whose entries are at least as long stay; the first shorter or empty cell takes
	// the new route and the rest move one place back.
	always_comb begin
		for (int i = 0; i < NN; i++) begin
			n_op[i] = OP_HOLD;
			if (apply_go) begin
				if (flush) begin
					n_op[i] = OP_CLEAR;
				end else if (n_ins) begin
					if (n_flag[i].keep) begin
						n_op[i] = OP_HOLD;
					end else if (i == 0) begin
						n_op[i] = OP_NEW;
					end else if (n_flag[(i == 0) ? 0 : i - 1].keep) begin
						n_op[i] = OP_NEW;
					end else begin
						n_op[i] = OP_PREV;
					end
				end else if (n_del && nd_seen[i+1]) begin
					n_op[i] = OP_NEXT;
				end
			end
		end
	end

	// Result register; it is loaded only when empty or being emptied in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			out_status_q <= res_status;
			out_hit_q    <= res_hit;
			out_ent_q    <= res_ent;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = {out_ent_q.kind, out_hit_q, out_status_q};
	assign m_axis_tdata  = {2'b00, out_ent_q.metric, out_ent_q.mtu, out_ent_q.src,
		out_ent_q.gw, out_ent_q.port, out_ent_q.plen};

	assign h_vld_inc = h_vld + {{(HN-1){1'b0}}, 1'b1};
	assign n_vld_inc = n_vld + {{(NN-1){1'b0}}, 1'b1};

	`IPRT_ASSERT_ALWAYS(a_host_packed, (h_vld & h_vld_inc) == '0, "host cells not packed")
	`IPRT_ASSERT_ALWAYS(a_net_packed, (n_vld & n_vld_inc) == '0, "net cells not packed")
	`IPRT_ASSERT_NEXT(a_apply_loads, apply_go, out_valid_q, "result not loaded")
	`IPRT_ASSERT_NEXT(a_accept_cmp, in_acc, state_q == S_CMP, "request not compared")
	`IPRT_ASSERT_NEXT(a_hit_ok, apply_go && res_hit, out_status_q == STS_OK, "hit with bad status")

endmodule

>>> rtl/iprt_cell.sv
// One route cell: holds an entry, shifts with its neighbors and compares it with a request.
`timescale 1ns / 1ps
module iprt_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  iprt_pkg::cell_op_t    op,
	input  iprt_pkg::entry_t      new_ent,
	input  iprt_pkg::entry_t      prev_ent,
	input  logic                  prev_valid,
	input  iprt_pkg::entry_t      next_ent,
	input  logic                  next_valid,
	input  iprt_pkg::query_t      query,
	input  logic                  cmp_en,
	output iprt_pkg::entry_t      ent,
	output logic                  valid,
	output iprt_pkg::cell_flags_t flags
);
	import iprt_pkg::*;

	entry_t      ent_q;
	logic        valid_q;
	cell_flags_t flags_q;
	cell_flags_t flags_d;
	logic [31:0] qmask;
	logic [31:0] omask;
	logic        port_eq;

	always_comb begin
		qmask   = plen_mask(query.plen);
		omask   = plen_mask(ent_q.plen);
		port_eq = ent_q.port == query.port;
		flags_d.addr_eq  = valid_q && (ent_q.addr == query.addr);
		flags_d.host_dup = valid_q && (ent_q.addr == query.addr) && port_eq;
		flags_d.net_dup  = valid_q && port_eq && (ent_q.plen == query.plen)
			&& ((ent_q.addr & qmask) == (query.addr & qmask));
		flags_d.keep     = valid_q && (ent_q.plen >= query.plen);
		flags_d.net_del  = valid_q && port_eq
			&& ((ent_q.addr & qmask) == (query.addr & qmask));
		flags_d.cover_hit = valid_q && ((ent_q.addr & omask) == (query.addr & omask));
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_NEW:  ent_q <= new_ent;
			OP_PREV: ent_q <= prev_ent;
			OP_NEXT: ent_q <= next_ent;
			default: ent_q <= ent_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			flags_q <= '0;
		end else begin
			case (op)
				OP_NEW:   valid_q <= 1'b1;
				OP_PREV:  valid_q <= prev_valid;
				OP_NEXT:  valid_q <= next_valid;
				OP_CLEAR: valid_q <= 1'b0;
				default:  valid_q <= valid_q;
			endcase
			if (cmp_en) begin
				flags_q <= flags_d;
			end
		end
	end

	assign ent   = ent_q;
	assign valid = valid_q;
	assign flags = flags_q;

endmodule

>>> bench/ipv4_route_table_lookup_checker.sv
// Checker for the route table: watches all channels, predicts each result and compares it.
`timescale 1ns / 1ps
module ipv4_route_table_lookup_checker
	import iprt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,
	input  logic [3:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [111:0] m_axis_tdata,
	input  logic [4:0]   m_axis_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [15:0]  cfg_data,
	output int           fail_count,
	output int           pending
);

	typedef struct packed {
		logic [15:0] metric;
		logic [15:0] mtu;
		logic [31:0] src;
		logic [31:0] gw;
		logic [7:0]  port;
		logic [5:0]  plen;
		logic [1:0]  kind;
		logic        hit;
		logic [1:0]  status;
	} route_answer_t;

	entry_t        host_tbl[HOST_ENTRIES];
	entry_t        net_tbl[NET_ENTRIES];
	int            host_used;
	int            net_used;
	logic [15:0]   mtu_default;
	route_answer_t answers_due[$];

	function automatic logic [31:0] net_mask(input logic [5:0] p);
		if (p == 0) return 32'd0;
		if (p >= 32) return 32'hFFFF_FFFF;
		return 32'hFFFF_FFFF << (32 - p);
	endfunction

	function automatic route_answer_t answer_from(input entry_t e);
		route_answer_t r;
		r = '0;
		r.hit = 1'b1;
		r.kind = e.kind;
		r.plen = e.plen;
		r.port = e.port;
		r.gw = e.gw;
		r.src = e.src;
		r.mtu = e.mtu;
		r.metric = e.metric;
		return r;
	endfunction

	// Applies one request to the shadow stores and returns the result it must produce.
	function automatic route_answer_t route_request(input logic [143:0] d, input logic [3:0] u);
		route_answer_t r;
		entry_t        ne;
		func_t         fn;
		logic [31:0]   m;
		int            i;
		int            pos;
		bit            dup;
		bit            found;
		r = '0;
		fn = func_t'(u[1:0]);
		ne.kind = u[3:2];
		ne.addr = d[31:0];
		ne.plen = (d[37:32] > 32) ? 6'd32 : d[37:32];
		ne.port = d[45:38];
		ne.gw = d[77:46];
		ne.src = d[109:78];
		ne.mtu = (d[125:110] == 0) ? mtu_default : d[125:110];
		ne.metric = d[141:126];
		m = net_mask(ne.plen);
		case (fn)
			FN_ADD: begin
				if (ne.kind < 2) begin
					dup = 0;
					for (i = 0; i < host_used; i++)
						if (host_tbl[i].addr == ne.addr && host_tbl[i].port == ne.port) dup = 1;
					if (dup) begin
						r.status = STS_EXISTS;
					end else if (host_used >= HOST_ENTRIES) begin
						r.status = STS_FULL;
					end else begin
						for (i = host_used; i > 0; i--) host_tbl[i] = host_tbl[i-1];
						host_tbl[0] = ne;
						host_used++;
					end
				end else begin
					pos = net_used;
					dup = 0;
					for (i = 0; i < net_used; i++) begin
						if (net_tbl[i].port == ne.port && net_tbl[i].plen == ne.plen &&
						    ((net_tbl[i].addr ^ ne.addr) & m) == 0) begin
							dup = 1;
							break;
						end
						if (net_tbl[i].plen < ne.plen) begin
							pos = i;
							break;
						end
					end
					if (dup) begin
						r.status = STS_EXISTS;
					end else if (net_used >= NET_ENTRIES) begin
						r.status = STS_FULL;
					end else begin
						for (i = net_used; i > pos; i--) net_tbl[i] = net_tbl[i-1];
						net_tbl[pos] = ne;
						net_used++;
					end
				end
			end
			FN_DEL: begin
				found = 0;
				if (ne.kind < 2) begin
					for (i = 0; i < host_used; i++)
						if (host_tbl[i].addr == ne.addr) begin
							found = 1;
							break;
						end
					if (found) begin
						for (; i + 1 < host_used; i++) host_tbl[i] = host_tbl[i+1];
						host_used--;
					end
				end else begin
					for (i = 0; i < net_used; i++)
						if (net_tbl[i].port == ne.port && ((net_tbl[i].addr ^ ne.addr) & m) == 0) begin
							found = 1;
							break;
						end
					if (found) begin
						for (; i + 1 < net_used; i++) net_tbl[i] = net_tbl[i+1];
						net_used--;
					end
				end
				if (!found) r.status = STS_MISS;
			end
			FN_LOOKUP: begin
				found = 0;
				for (i = 0; i < host_used && !found; i++)
					if (host_tbl[i].addr == ne.addr) begin
						r = answer_from(host_tbl[i]);
						found = 1;
					end
				for (i = 0; i < net_used && !found; i++)
					if (((net_tbl[i].addr ^ ne.addr) & net_mask(net_tbl[i].plen)) == 0) begin
						r = answer_from(net_tbl[i]);
						found = 1;
					end
				if (!found) r.status = STS_MISS;
			end
			default: begin
				host_used = 0;
				net_used = 0;
			end
		endcase
		return r;
	endfunction

	task automatic compare_field(input string nm, input logic [31:0] e, input logic [31:0] a);
		if (e !== a) begin
			$error("%s mismatch: expected %0h, got %0h", nm, e, a);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		route_answer_t e;
		route_answer_t a;
		if (!arst_n) begin
			host_used = 0;
			net_used = 0;
			mtu_default = DEFAULT_MTU_RESET;
			fail_count = 0;
			answers_due.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) mtu_default = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				answers_due.push_back(route_request(s_axis_tdata, s_axis_tuser));
			if (m_axis_tvalid && m_axis_tready) begin
				a.status = m_axis_tuser[1:0];
				a.hit = m_axis_tuser[2];
				a.kind = m_axis_tuser[4:3];
				a.plen = m_axis_tdata[5:0];
				a.port = m_axis_tdata[13:6];
				a.gw = m_axis_tdata[45:14];
				a.src = m_axis_tdata[77:46];
				a.mtu = m_axis_tdata[93:78];
				a.metric = m_axis_tdata[109:94];
				if (answers_due.size() == 0) begin
					$error("result transfer with no request outstanding");
					fail_count++;
				end else begin
					e = answers_due.pop_front();
					compare_field("status", e.status, a.status);
					compare_field("hit", e.hit, a.hit);
					compare_field("hit_kind", e.kind, a.kind);
					compare_field("hit_prefix_len", e.plen, a.plen);
					compare_field("hit_port", e.port, a.port);
					compare_field("hit_gateway", e.gw, a.gw);
					compare_field("hit_source", e.src, a.src);
					compare_field("hit_mtu", e.mtu, a.mtu);
					compare_field("hit_metric", e.metric, a.metric);
				end
			end
			pending = answers_due.size();
		end
	end

endmodule

>>> bench/ipv4_route_table_lookup_tb.sv
// Testbench top for the route table: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 1ps
module ipv4_route_table_lookup_tb;
	import iprt_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata = '0;
	logic [3:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [111:0] m_axis_tdata;
	logic [4:0]   m_axis_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [15:0]  cfg_data = '0;
	int           fail_count;
	int           pending;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           quiet_cycles = 0;
	int           flush_pct;

	// A small pool of base addresses so that adds, deletes and lookups collide often.
	logic [31:0] addr_pool[8] = '{32'h0A00_0001, 32'hC0A8_0101, 32'hFFFF_FFFF, 32'h0000_0000,
	                              32'hAC10_2040, 32'h0A00_0100, 32'h8000_0000, 32'h7FFF_FFFF};

	always #5 clk = ~clk;

	ipv4_route_table_lookup u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	ipv4_route_table_lookup_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// The receiver stalls at random, changing its ready only at the falling edge.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Watchdog: a long stretch with no transfer on any channel means the block hung.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= 5000) begin
			$display("FAIL ipv4_route_table_lookup");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Drives one request transfer; entered and left at a falling edge.
	task automatic send_route_op(input func_t fn, input logic [1:0] kind, input logic [31:0] dst,
	                             input logic [5:0] plen, input logic [7:0] port,
	                             input logic [31:0] gw, input logic [31:0] src,
	                             input logic [15:0] mtu, input logic [15:0] metric);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {2'b00, metric, mtu, src, gw, port, plen, dst};
		s_axis_tuser = {kind, fn};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// Waits for every result, lets the block settle, then writes default_mtu.
	task automatic write_default_mtu(input logic [15:0] val);
		while (pending != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One random request, biased toward addresses from the pool so that routes get hit.
	task automatic send_random_op();
		func_t       fn;
		int          pick;
		logic [31:0] dst;
		logic [5:0]  plen;
		logic [1:0]  kind;
		pick = $urandom_range(99);
		if (pick < flush_pct) fn = FN_FLUSH;
		else if (pick < 45) fn = FN_ADD;
		else if (pick < 65) fn = FN_DEL;
		else fn = FN_LOOKUP;
		dst = addr_pool[$urandom_range(7)];
		case ($urandom_range(3))
			0: dst = $urandom;
			1: dst = dst ^ ($urandom & 32'h0000_00FF);
			default: ;
		endcase
		plen = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32));
		kind = 2'($urandom_range(3));
		send_route_op(fn, kind, dst, plen, $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3)),
		              $urandom, $urandom, $urandom_range(3) == 0 ? 16'd0 : 16'($urandom),
		              16'($urandom));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: misses on empty stores, every operation, duplicates, prefix clamp,
		// default MTU and the field extremes.
		send_route_op(FN_LOOKUP, 2'd0, 32'h0A00_0001, 6'd32, 8'd0, 0, 0, 0, 0);
		send_route_op(FN_DEL, 2'd0, 32'h0A00_0001, 6'd32, 8'd0, 0, 0, 0, 0);
		send_route_op(FN_DEL, 2'd2, 32'h0A00_0001, 6'd8, 8'd0, 0, 0, 0, 0);
		send_route_op(FN_ADD, 2'd0, 32'h0A00_0001, 6'd32, 8'd1, 32'h1, 32'h2, 16'd0, 16'h8000);
		send_route_op(FN_ADD, 2'd0, 32'h0A00_0001, 6'd32, 8'd1, 0, 0, 16'd9000, 0);
		send_route_op(FN_ADD, 2'd1, 32'h0A00_0001, 6'd32, 8'd255, 32'hFFFF_FFFF,
		              32'hFFFF_FFFF, 16'hFFFF, 16'h7FFF);
		send_route_op(FN_LOOKUP, 2'd3, 32'h0A00_0001, 6'd0, 8'd0, 0, 0, 0, 0);
		send_route_op(FN_ADD, 2'd2, 32'hFFFF_FFFF, 6'd63, 8'd255, 32'h5, 0, 16'd1, 16'hFFFF);
		send_route_op(FN_ADD, 2'd2, 32'h0A01_0000, 6'd16, 8'd2, 32'h6, 32'h7, 0, 16'd5);
		send_route_op(FN_ADD, 2'd2, 32'h0A01_FFFF, 6'd16, 8'd2, 0, 0, 0, 0);
		send_route_op(FN_ADD, 2'd2, 32'h0A01_0000, 6'd16, 8'd3, 0, 0, 0, 0);
		send_route_op(FN_ADD, 2'd3, 32'h0000_0000, 6'd0, 8'd0, 32'h9, 0, 0, 0);
		send_route_op(FN_LOOKUP, 2'd0, 32'hFFFF_FFFF, 6'd0, 8'd0, 0, 0, 0, 0);
		send_route_op(FN_LOOKUP, 2'd0, 32'h0A01_1234, 6'd0, 8'd0, 0, 0, 0, 0);
		send_route_op(FN_LOOKUP, 2'd0, 32'h2000_0000, 6'd0, 8'd0, 0, 0, 0, 0);
		send_route_op(FN_DEL, 2'd2, 32'h0A01_5555, 6'd16, 8'd3, 0, 0, 0, 0);
		send_route_op(FN_DEL, 2'd1, 32'h0A00_0001, 6'd0, 8'd7, 0, 0, 0, 0);
		send_route_op(FN_LOOKUP, 2'd0, 32'h0A00_0001, 6'd0, 8'd0, 0, 0, 0, 0);
		send_route_op(FN_DEL, 2'd3, 32'h1234_5678, 6'd40, 8'd255, 0, 0, 0, 0);
		send_route_op(FN_FLUSH, 2'd0, 0, 0, 0, 0, 0, 0, 0);
		send_route_op(FN_LOOKUP, 2'd0, 32'h0A00_0001, 6'd0, 8'd0, 0, 0, 0, 0);

		// Random part in three phases with different flow control and default MTU.
		// The first phase never flushes, so entries accumulate in both stores.
		write_default_mtu(16'd68);
		send_idle_pct = 31;
		recv_stall_pct = 61;
		flush_pct = 0;
		repeat (270) send_random_op();

		write_default_mtu(16'hFFFF);
		send_idle_pct = 61;
		recv_stall_pct = 31;
		flush_pct = 2;
		repeat (270) send_random_op();

		write_default_mtu(16'h5A5A);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		flush_pct = 1;
		repeat (270) send_random_op();

		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("PASS ipv4_route_table_lookup");
		end else begin
			$display("FAIL ipv4_route_table_lookup");
		end
		$finish;
	end

endmodule
